// ===== hw/rtl/rasum_pkg.sv =====
// ----------------------------------------------------------------------------
// rasum_pkg
// shared constants, types and state encoding for the range add / range sum unit
// ----------------------------------------------------------------------------
package rasum_pkg;

    localparam int MAX_LENGTH = 65536;
    localparam int IDX_W      = $clog2(MAX_LENGTH + 1);
    localparam int MEM_DEPTH  = MAX_LENGTH + 1;
    localparam int SUM_W      = 64;
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 17;
    localparam int ADDR_W     = 2;
    localparam int DATA_W     = 32;

    localparam logic [CFG_W-1:0]  LEN_RESET = CFG_W'(MAX_LENGTH);
    localparam logic [ADDR_W-1:0] ADDR_LEN  = '0;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_QRY_RD,
        ST_QRY_ACC,
        ST_QRY_MUL,
        ST_QRY_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                    operation;
        logic [CFG_W-1:0]        left_index;
        logic [CFG_W-1:0]        right_index;
        logic signed [VAL_W-1:0] add_value;
    } item_t;

endpackage

// ===== hw/rtl/range_add_range_sum_tree_unit.sv =====
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_unit
// range add and range sum over a 65536-entry signed 64-bit array
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one item: operation, left_index,
// right_index, add_value. An add produces no result; a query produces one
// range_sum item on the output channel (out_valid / out_stall).
// State lives in one node memory holding two prefix trees; every item with a
// non-empty range walks them one node at a time (read, then write or add).
// An add touches up to 2 x 17 nodes.
// A query reads up to 2 x 16 nodes, with a multiply step and a combine step
// after each walk, then loads the output register.
// After reset all 65537 memory words are cleared; in_stall stays high
// meanwhile, configuration writes are taken as usual.
// A waiting result sits in the output register; the next item is taken and
// worked on, and only its own result waits for out_stall to drop.
// array_length is written over the apb port at address 0.
module range_add_range_sum_tree_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rasum_pkg::ADDR_W-1:0]        paddr,
    input  logic [rasum_pkg::DATA_W-1:0]        pwdata,
    output logic [rasum_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [rasum_pkg::CFG_W-1:0]         left_index,
    input  logic [rasum_pkg::CFG_W-1:0]         right_index,
    input  logic signed [rasum_pkg::VAL_W-1:0]  add_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rasum_pkg::SUM_W-1:0]  range_sum
);

    logic [rasum_pkg::CFG_W-1:0] array_length;
    rasum_pkg::item_t            item;

    assign item.operation   = operation;
    assign item.left_index  = left_index;
    assign item.right_index = right_index;
    assign item.add_value   = add_value;

    rasum_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .array_length (array_length)
    );

    rasum_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .array_length (array_length),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .item         (item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .range_sum    (range_sum)
    );

endmodule

// ===== hw/rtl/rasum_cfg.sv =====
// ----------------------------------------------------------------------------
// rasum_cfg
// apb register block holding the array length
// ----------------------------------------------------------------------------
module rasum_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rasum_pkg::ADDR_W-1:0]    paddr,
    input  logic [rasum_pkg::DATA_W-1:0]    pwdata,
    output logic [rasum_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    output logic [rasum_pkg::CFG_W-1:0]     array_length
);

    logic [rasum_pkg::CFG_W-1:0] len_reg;
    logic [rasum_pkg::CFG_W-1:0] len_next;

    always_comb
    begin
        len_next = len_reg;
        if (psel && penable && pwrite && paddr == rasum_pkg::ADDR_LEN)
        begin
            len_next = pwdata[rasum_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= rasum_pkg::LEN_RESET;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    assign pready       = 1'b1;
    assign prdata       = (paddr == rasum_pkg::ADDR_LEN)
                          ? rasum_pkg::DATA_W'(len_reg) : '0;
    assign array_length = len_reg;

endmodule

// ===== hw/rtl/rasum_engine.sv =====
// ----------------------------------------------------------------------------
// rasum_engine
// two fenwick trees in one node memory, walked by read-modify-write steps on adds and read-accumulate steps on queries
// ----------------------------------------------------------------------------
module rasum_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [rasum_pkg::CFG_W-1:0]         array_length,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rasum_pkg::item_t                    item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rasum_pkg::SUM_W-1:0]  range_sum
);

    localparam int IW = rasum_pkg::IDX_W;
    localparam int SW = rasum_pkg::SUM_W;

    // each word holds {tree one, tree two}
    logic [2*SW-1:0] mem [rasum_pkg::MEM_DEPTH];
    logic [2*SW-1:0] rd_data;
    logic [IW-1:0]   rd_addr;
    logic [IW-1:0]   wr_addr;
    logic [2*SW-1:0] wr_data;
    logic            wr_en;

    rasum_pkg::state_t state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic          phase_reg, phase_next;
    logic [IW-1:0] ql_reg, ql_next;
    logic [IW-1:0] qh_reg, qh_next;
    logic [SW-1:0] v_reg, v_next;
    logic [SW-1:0] d2a_reg, d2a_next;
    logic [SW-1:0] d2b_reg, d2b_next;
    logic [SW-1:0] s1_reg, s1_next;
    logic [SW-1:0] s2_reg, s2_next;
    logic [SW-1:0] prod_reg, prod_next;
    logic [SW-1:0] res_reg, res_next;
    logic          ov_reg, ov_next;
    logic [SW-1:0] sum_reg, sum_next;

    logic [IW-1:0]   len_c, ql_c, qh_c;
    logic            empty_c;
    logic [IW:0]     pos_up;
    logic [IW-1:0]   pos_dn;
    logic [IW-1:0]   lowbit;
    logic [IW-1:0]   ph1_pos;
    logic [SW-1:0]   vext;
    logic [SW-1:0]   d1_c, d2_c;
    logic [IW-1:0]   mul_p;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    always_comb
    begin
        // length and range clamping
        len_c = (array_length > rasum_pkg::CFG_W'(rasum_pkg::MAX_LENGTH))
                ? IW'(rasum_pkg::MAX_LENGTH) : IW'(array_length);
        ql_c  = (item.left_index == '0) ? IW'(1) : IW'(item.left_index);
        qh_c  = (IW'(item.right_index) > len_c) ? len_c : IW'(item.right_index);
        empty_c = (len_c == '0) || (ql_c > qh_c);
        vext  = SW'(item.add_value);

        lowbit = pos_reg & (~pos_reg + IW'(1));
        pos_up = {1'b0, pos_reg} + {1'b0, lowbit};
        pos_dn = pos_reg - lowbit;
        ph1_pos = qh_reg + IW'(1);
        d1_c  = phase_reg ? (~v_reg + SW'(1)) : v_reg;
        d2_c  = phase_reg ? (~d2b_reg + SW'(1)) : d2a_reg;
        mul_p = phase_reg ? (ql_reg - IW'(1)) : qh_reg;

        state_next = state_reg;
        clr_next   = clr_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        ql_next    = ql_reg;
        qh_next    = qh_reg;
        v_next     = v_reg;
        d2a_next   = d2a_reg;
        d2b_next   = d2b_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        sum_next   = sum_reg;
        rd_addr    = pos_reg;
        wr_addr    = pos_reg;
        wr_data    = {rd_data[2*SW-1:SW] + d1_c, rd_data[SW-1:0] + d2_c};
        wr_en      = 1'b0;
        in_stall   = 1'b1;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            rasum_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(rasum_pkg::MAX_LENGTH))
                begin
                    state_next = rasum_pkg::ST_IDLE;
                end
            end
            rasum_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ql_next    = ql_c;
                    qh_next    = qh_c;
                    v_next     = vext;
                    d2a_next   = SW'($signed(item.add_value)
                                     * $signed({1'b0, ql_c - IW'(1)}));
                    d2b_next   = SW'($signed(item.add_value) * $signed({1'b0, qh_c}));
                    phase_next = 1'b0;
                    s1_next    = '0;
                    s2_next    = '0;
                    res_next   = '0;
                    pos_next   = (item.operation == rasum_pkg::OP_ADD) ? ql_c : qh_c;
                    if (item.operation == rasum_pkg::OP_ADD)
                    begin
                        state_next = empty_c ? rasum_pkg::ST_IDLE : rasum_pkg::ST_UPD_RD;
                    end
                    else
                    begin
                        state_next = empty_c ? rasum_pkg::ST_OUT : rasum_pkg::ST_QRY_RD;
                    end
                end
            end
            rasum_pkg::ST_UPD_RD:
            begin
                state_next = rasum_pkg::ST_UPD_WR;
            end
            rasum_pkg::ST_UPD_WR:
            begin
                wr_en = 1'b1;
                if (pos_up > (IW+1)'(rasum_pkg::MAX_LENGTH))
                begin
                    // walk done, second point sits at right end plus one
                    if (!phase_reg && ph1_pos <= IW'(rasum_pkg::MAX_LENGTH))
                    begin
                        phase_next = 1'b1;
                        pos_next   = ph1_pos;
                        state_next = rasum_pkg::ST_UPD_RD;
                    end
                    else
                    begin
                        state_next = rasum_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    pos_next   = pos_up[IW-1:0];
                    state_next = rasum_pkg::ST_UPD_RD;
                end
            end
            rasum_pkg::ST_QRY_RD:
            begin
                state_next = rasum_pkg::ST_QRY_ACC;
            end
            rasum_pkg::ST_QRY_ACC:
            begin
                s1_next  = s1_reg + rd_data[2*SW-1:SW];
                s2_next  = s2_reg + rd_data[SW-1:0];
                pos_next = pos_dn;
                state_next = (pos_dn == '0) ? rasum_pkg::ST_QRY_MUL : rasum_pkg::ST_QRY_RD;
            end
            rasum_pkg::ST_QRY_MUL:
            begin
                // prefix(p) = p * tree one - tree two
                prod_next  = SW'(s1_reg * {{(SW-IW){1'b0}}, mul_p});
                state_next = rasum_pkg::ST_QRY_FIN;
            end
            rasum_pkg::ST_QRY_FIN:
            begin
                res_next = phase_reg ? (res_reg - (prod_reg - s2_reg))
                                     : (res_reg + (prod_reg - s2_reg));
                s1_next  = '0;
                s2_next  = '0;
                if (phase_reg)
                begin
                    state_next = rasum_pkg::ST_OUT;
                end
                else
                begin
                    phase_next = 1'b1;
                    pos_next   = ql_reg - IW'(1);
                    state_next = (ql_reg == IW'(1)) ? rasum_pkg::ST_QRY_MUL
                                                    : rasum_pkg::ST_QRY_RD;
                end
            end
            rasum_pkg::ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    sum_next   = res_reg;
                    state_next = rasum_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rasum_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rasum_pkg::ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        phase_reg <= phase_next;
        ql_reg    <= ql_next;
        qh_reg    <= qh_next;
        v_reg     <= v_next;
        d2a_reg   <= d2a_next;
        d2b_reg   <= d2b_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        sum_reg   <= sum_next;
    end

    assign out_valid = ov_reg;
    assign range_sum = sum_reg;

endmodule

// ===== bench/range_add_range_sum_tree_unit_tb.sv =====
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_unit_tb
// checks range adds and range sums against a fenwick-based predictor
// ----------------------------------------------------------------------------
// Items are queued per phase by the sequencer, driven at the falling edge with
// random gaps, and every query result is compared with the predicted sum.
// Between phases the array length is rewritten over the apb port.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                                op;
        logic [rasum_pkg::CFG_W-1:0]         lidx;
        logic [rasum_pkg::CFG_W-1:0]         ridx;
        logic [rasum_pkg::VAL_W-1:0]         val;
    } range_op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [rasum_pkg::ADDR_W-1:0] paddr = '0;
    logic [rasum_pkg::DATA_W-1:0] pwdata = '0;
    logic [rasum_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = 1'b0;
    logic [rasum_pkg::CFG_W-1:0] left_index = '0, right_index = '0;
    logic signed [rasum_pkg::VAL_W-1:0] add_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [rasum_pkg::SUM_W-1:0] range_sum;

    range_add_range_sum_tree_unit dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // two fenwick trees give range add / prefix sum, all modulo 2^64
    logic [63:0] fw_slope [1:rasum_pkg::MAX_LENGTH+1];
    logic [63:0] fw_offs  [1:rasum_pkg::MAX_LENGTH+1];
    logic [rasum_pkg::CFG_W-1:0] cur_length = rasum_pkg::LEN_RESET;

    range_op_t pending_ops[$];
    logic [63:0] expected_sums[$];
    int fails = 0;
    int accepted = 0;
    int queries_seen = 0;
    int adds_seen = 0;
    bit fired = 1'b0;

    function automatic void fw_update(int pos, logic [63:0] slope, logic [63:0] offs);
        int k;
        k = pos;
        while (k <= rasum_pkg::MAX_LENGTH + 1)
        begin
            fw_slope[k] += slope;
            fw_offs[k]  += offs;
            k += k & (-k);
        end
    endfunction

    function automatic logic [63:0] prefix_sum(int pos);
        logic [63:0] s1, s2;
        int k;
        s1 = '0;
        s2 = '0;
        k = pos;
        while (k > 0)
        begin
            s1 += fw_slope[k];
            s2 += fw_offs[k];
            k -= k & (-k);
        end
        return s1 * 64'(pos) - s2;
    endfunction

    // applies one accepted item; returns 1 with the sum for a query
    function automatic bit apply_range_op(range_op_t it, output logic [63:0] sum);
        int len, lo, hi;
        logic [63:0] v;
        v = {{32{it.val[31]}}, it.val};
        len = (cur_length > rasum_pkg::MAX_LENGTH) ? rasum_pkg::MAX_LENGTH
                                                   : int'(cur_length);
        lo = (it.lidx < 1) ? 1 : int'(it.lidx);
        hi = (int'(it.ridx) > len) ? len : int'(it.ridx);
        sum = '0;
        if (it.op == rasum_pkg::OP_ADD)
        begin
            if (len != 0 && lo <= hi)
            begin
                fw_update(lo, v, v * 64'(lo - 1));
                fw_update(hi + 1, -v, -(v * 64'(hi)));
            end
            return 1'b0;
        end
        if (len != 0 && lo <= hi)
            sum = prefix_sum(hi) - prefix_sum(lo - 1);
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    function automatic range_op_t random_range_op(int len);
        range_op_t it;
        int r, span, lim;
        it.op = 1'($urandom_range(0, 1));
        lim = (len < 1) ? 1 : ((len > rasum_pkg::MAX_LENGTH) ? rasum_pkg::MAX_LENGTH : len);
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            it.lidx = rasum_pkg::CFG_W'($urandom_range(0, lim + 1));
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, lim) : $urandom_range(0, 40);
            it.ridx = rasum_pkg::CFG_W'(int'(it.lidx) + span);
            if ($urandom_range(0, 9) == 0)
                it.ridx = rasum_pkg::CFG_W'($urandom_range(0, lim));
        end
        else
        begin
            it.lidx = rasum_pkg::CFG_W'($urandom);
            it.ridx = rasum_pkg::CFG_W'($urandom);
        end
        r = $urandom_range(0, 9);
        if (r < 5)
            it.val = $urandom;
        else if (r < 8)
            it.val = rasum_pkg::VAL_W'($urandom_range(0, 200) - 100);
        else
            it.val = (r == 8) ? 32'h7fff_ffff : 32'h8000_0000;
        return it;
    endfunction

    // input side: one valid assignment per falling edge
    int in_gap = 0;
    always @(negedge clk)
    begin
        logic nv;
        range_op_t it;
        nv = in_valid;
        if (!in_valid || fired)
        begin
            nv = 1'b0;
            if (in_gap > 0)
                in_gap--;
            else if (pending_ops.size() > 0)
            begin
                it = pending_ops.pop_front();
                operation   <= it.op;
                left_index  <= it.lidx;
                right_index <= it.ridx;
                add_value   <= it.val;
                nv = 1'b1;
                in_gap = pick_gap();
            end
        end
        in_valid <= nv;
    end

    // receiver stall, with one long hold-off once the run is well under way
    int stall_cnt = 0;
    bit long_done = 1'b0;
    always @(negedge clk)
    begin
        if (!long_done && accepted >= 500)
        begin
            long_done = 1'b1;
            stall_cnt = 3000;
        end
        if (stall_cnt > 0)
        begin
            stall_cnt--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_cnt = pick_gap();
        end
    end

    // accept items, predict, and check results
    always @(posedge clk)
    begin
        range_op_t it;
        logic [63:0] s;
        fired = in_valid && !in_stall;
        if (fired)
        begin
            it.op = operation;
            it.lidx = left_index;
            it.ridx = right_index;
            it.val = add_value;
            accepted++;
            if (apply_range_op(it, s))
            begin
                expected_sums.push_back(s);
                queries_seen++;
            end
            else
                adds_seen++;
        end
        if (out_valid && !out_stall)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("range_sum: unexpected result %0d", range_sum);
                fails++;
            end
            else
            begin
                s = expected_sums.pop_front();
                if (range_sum !== s)
                begin
                    $error("range_sum: expected %0d, actual %0d", $signed(s), range_sum);
                    fails++;
                end
            end
        end
    end

    // block is idle once nothing is queued, offered, busy or owed
    task automatic wait_idle();
        while (pending_ops.size() > 0 || in_valid || in_stall || expected_sums.size() > 0)
            @(posedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_length(logic [rasum_pkg::CFG_W-1:0] len);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= rasum_pkg::ADDR_LEN;
        pwdata <= rasum_pkg::DATA_W'(len);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cur_length = len;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_op(logic op, int l, int r, logic [rasum_pkg::VAL_W-1:0] v);
        range_op_t it;
        it.op = op;
        it.lidx = rasum_pkg::CFG_W'(l);
        it.ridx = rasum_pkg::CFG_W'(r);
        it.val = v;
        pending_ops.push_back(it);
    endtask

    task automatic random_phase(logic [rasum_pkg::CFG_W-1:0] len, int count);
        write_length(len);
        repeat (count) pending_ops.push_back(random_range_op(int'(len)));
        wait_idle();
    endtask

    initial
    begin
        for (int k = 1; k <= rasum_pkg::MAX_LENGTH + 1; k++)
        begin
            fw_slope[k] = '0;
            fw_offs[k] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, clamping, empty ranges, wrap-around
        push_op(rasum_pkg::OP_QUERY, 1, rasum_pkg::MAX_LENGTH, 32'h1234_5678);
        push_op(rasum_pkg::OP_ADD, 1, rasum_pkg::MAX_LENGTH, 32'h7fff_ffff);
        push_op(rasum_pkg::OP_ADD, 0, 131071, 32'h7fff_ffff);
        push_op(rasum_pkg::OP_QUERY, 0, 131071, 32'h0);
        push_op(rasum_pkg::OP_ADD, 1, 1, 32'h8000_0000);
        push_op(rasum_pkg::OP_ADD, rasum_pkg::MAX_LENGTH, rasum_pkg::MAX_LENGTH, 32'h8000_0000);
        push_op(rasum_pkg::OP_QUERY, 1, 1, 32'hffff_ffff);
        push_op(rasum_pkg::OP_QUERY, rasum_pkg::MAX_LENGTH, rasum_pkg::MAX_LENGTH, 32'h0);
        push_op(rasum_pkg::OP_QUERY, 0, 0, 32'h0);
        push_op(rasum_pkg::OP_ADD, 0, 0, 32'h5);
        push_op(rasum_pkg::OP_QUERY, 10, 9, 32'h0);
        push_op(rasum_pkg::OP_ADD, 10, 9, 32'h7);
        push_op(rasum_pkg::OP_QUERY, 131071, 131071, 32'h0);
        push_op(rasum_pkg::OP_ADD, 2, 65535, 32'hffff_ffff);
        push_op(rasum_pkg::OP_QUERY, 2, 65535, 32'h0);
        push_op(rasum_pkg::OP_QUERY, 32768, 32769, 32'h0);
        for (int p = 1; p <= 6; p++)
            push_op(rasum_pkg::OP_ADD, p, p, 32'(p * 1000 - 3000));
        push_op(rasum_pkg::OP_QUERY, 1, 6, 32'h0);
        push_op(rasum_pkg::OP_QUERY, 3, 100000, 32'h0);
        wait_idle();

        random_phase(17'd37, 300);
        random_phase(17'd0, 30);
        random_phase(17'h1ffff, 300);
        random_phase(17'd1, 50);
        random_phase(17'd65536, 300);
        random_phase(17'd2000, 270);

        $display("covered %0d items: %0d adds, %0d queries, six array lengths",
                 accepted, adds_seen, queries_seen);
        $display("lengths 0, 1, 37, 2000, 65536 and above the maximum were exercised");
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
